// ----- rtl/core/source_text_tokenizer_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the source text tokenizer core
// Each macro expands to one labeled concurrent assertion that is clocked on
// clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_ASSERT_SVH

// The condition implies the property in the same cycle.
`define STT_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("tokenizer assertion failed");

// The condition implies the property in the next cycle.
`define STT_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("tokenizer assertion failed");

`endif

// ----- rtl/core/stt_pkg.sv -----
// ---------------------------------------------------------------------------
// stt_pkg
// Types, codes, character constants and helper functions of the tokenizer.
// ---------------------------------------------------------------------------
package stt_pkg;

    localparam int OFFSET_BITS   = 16;
    localparam int KEYWORD_CHARS = 5;
    localparam int KEYWORD_COUNT = 8;
    localparam int LEN_BITS      = OFFSET_BITS + 1;
    localparam int PREFIX_BITS   = 8 * KEYWORD_CHARS;
    localparam int EXT_BITS      = LEN_BITS + 16;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int COUNT_BITS    = $clog2(FIFO_DEPTH + 1);

    typedef logic [2:0]             kind_t;
    typedef logic [2:0]             kw_t;
    typedef logic [15:0]            field16_t;
    typedef logic [7:0]             sym_t;
    typedef logic [1:0]             err_t;
    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [LEN_BITS-1:0]    len_t;

    localparam kind_t KIND_KEYWORD = 3'd0;
    localparam kind_t KIND_IDENT   = 3'd1;
    localparam kind_t KIND_UINT    = 3'd2;
    localparam kind_t KIND_DEC     = 3'd3;
    localparam kind_t KIND_DELIM   = 3'd4;
    localparam kind_t KIND_END     = 3'd5;
    localparam kind_t KIND_ERROR   = 3'd6;

    localparam err_t ERR_EXPECT_DELIM = 2'd0;
    localparam err_t ERR_EXPECT_DIGIT = 2'd1;
    localparam err_t ERR_UNEXPECTED   = 2'd2;

    localparam sym_t CH_NUL   = 8'h00;
    localparam sym_t CH_TAB   = 8'h09;
    localparam sym_t CH_CR    = 8'h0D;
    localparam sym_t CH_SPACE = 8'h20;
    localparam sym_t CH_MINUS = 8'h2D;
    localparam sym_t CH_POINT = 8'h2E;
    localparam sym_t CH_ZERO  = 8'h30;
    localparam sym_t CH_NINE  = 8'h39;
    localparam sym_t CH_GT    = 8'h3E;
    localparam sym_t CH_UA    = 8'h41;
    localparam sym_t CH_UZ    = 8'h5A;
    localparam sym_t CH_LA    = 8'h61;
    localparam sym_t CH_LZ    = 8'h7A;

    localparam int DELIM_COUNT = 12;
    // ; ( ) + - * / < > , = .
    localparam sym_t DELIM_SET [DELIM_COUNT] = '{
        8'h3B, 8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2A,
        8'h2F, 8'h3C, 8'h3E, 8'h2C, 8'h3D, 8'h2E
    };

    // Keyword text, first character in the low byte.
    localparam logic [63:0] KW_TEXT [KEYWORD_COUNT] = '{
        64'h6C636564,    // decl
        64'h746572,      // ret
        64'h746E697270,  // print
        64'h6669,        // if
        64'h656C696877,  // while
        64'h726F66,      // for
        64'h646E61,      // and
        64'h726F         // or
    };
    localparam int KW_LEN [KEYWORD_COUNT] = '{4, 3, 5, 2, 5, 3, 3, 2};

    typedef struct packed {
        kind_t    token_kind;
        kw_t      keyword_index;
        field16_t start_offset;
        field16_t token_length;
        sym_t     symbol;
        logic     is_arrow;
        err_t     error_kind;
        logic     last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic logic is_digit(sym_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(sym_t c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
    endfunction

    function automatic logic is_space(sym_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_delim(sym_t c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < DELIM_COUNT; i++)
        begin
            if (c == DELIM_SET[i])
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic ends_token(sym_t c);
        return (c == CH_NUL) || is_space(c) || is_delim(c);
    endfunction

    function automatic field16_t sat16(len_t v);
        logic [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(v);
        if (ext > EXT_BITS'(16'hFFFF))
        begin
            return 16'hFFFF;
        end
        return ext[15:0];
    endfunction

    function automatic res_t make_res(kind_t kind, kw_t kw, offset_t start, len_t len,
                                      sym_t sym, logic arrow, err_t err);
        res_t r;
        r.token_kind    = kind;
        r.keyword_index = kw;
        r.start_offset  = sat16(LEN_BITS'(start));
        r.token_length  = sat16(len);
        r.symbol        = sym;
        r.is_arrow      = arrow;
        r.error_kind    = err;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/core/stt_text_if.sv -----
// ---------------------------------------------------------------------------
// stt_text_if
// Source text channel: one byte per item.
// ---------------------------------------------------------------------------
interface stt_text_if;
    import stt_pkg::*;

    logic valid;
    logic ready;
    sym_t text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

// ----- rtl/core/stt_token_if.sv -----
// ---------------------------------------------------------------------------
// stt_token_if
// Token channel: one token or error result per item.
// ---------------------------------------------------------------------------
interface stt_token_if;
    import stt_pkg::*;

    logic     valid;
    logic     ready;
    kind_t    token_kind;
    kw_t      keyword_index;
    field16_t start_offset;
    field16_t token_length;
    sym_t     symbol;
    logic     is_arrow;
    err_t     error_kind;
    logic     last;

    modport source (
        output valid, output token_kind, output keyword_index, output start_offset,
        output token_length, output symbol, output is_arrow, output error_kind,
        output last, input ready
    );
    modport sink (
        input valid, input token_kind, input keyword_index, input start_offset,
        input token_length, input symbol, input is_arrow, input error_kind,
        input last, output ready
    );
endinterface

// ----- rtl/core/source_text_tokenizer_core.sv -----
// ---------------------------------------------------------------------------
// source_text_tokenizer_core
// Streaming lexical tokenizer: source bytes in, tokens with offsets out.
// ---------------------------------------------------------------------------
//
//   channel   direction   item                      handshake
//   text      in          one source byte           valid / ready
//   tokens    out         one token or error        valid / ready
//
// One byte is taken per cycle. Its token results are formed in the same cycle
// by the scanner logic and written into a four-entry result queue at the edge.
// A byte causes zero, one or two results; the queue drains one per cycle.
// text.ready is low only while the queue lacks room for two results, so with
// a free sink a byte is taken every cycle, except in a run of bytes that each
// cause two results, which fills the queue so that text.ready drops after
// each such byte until a result drains.
// Reset (rst_n low, asynchronous) empties the queue and puts the scanner idle
// at offset zero; the end byte does the same to the scanner.
`include "source_text_tokenizer_core_assert.svh"

module source_text_tokenizer_core (
    input  logic        clk,
    input  logic        rst_n,
    stt_text_if.sink    text,
    stt_token_if.source tokens
);
    import stt_pkg::*;

    logic  accept;
    logic  pop;
    logic  not_empty;
    logic  has_room;
    push_t push;
    res_t  head;

    // A byte is taken only when the queue can hold everything it may cause.
    assign text.ready = has_room;
    assign accept     = text.valid && text.ready;
    assign pop        = tokens.valid && tokens.ready;

    // Scanner: mode, position, open token start and leading identifier bytes.
    stt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text.text_byte),
        .push      (push)
    );

    // Result queue decouples the two sides of the block.
    stt_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .has_room  (has_room)
    );

    assign tokens.valid         = not_empty;
    assign tokens.token_kind    = head.token_kind;
    assign tokens.keyword_index = head.keyword_index;
    assign tokens.start_offset  = head.start_offset;
    assign tokens.token_length  = head.token_length;
    assign tokens.symbol        = head.symbol;
    assign tokens.is_arrow      = head.is_arrow;
    assign tokens.error_kind    = head.error_kind;
    assign tokens.last          = head.last;

    // A byte that causes results shows one on the output in the next cycle.
    `STT_ASSERT_NEXT(a_result_shows, accept && (push.count != 2'd0), tokens.valid)
    // The input stalls only while results wait in the queue.
    `STT_ASSERT_IMP(a_stall_has_cause, !text.ready, tokens.valid)
    // Of two results from one byte, only the second carries the last mark.
    `STT_ASSERT_IMP(a_last_mark, accept && (push.count == 2'd2),
                    !push.first.last && push.second.last)

endmodule

// ----- rtl/core/stt_scan.sv -----
// ---------------------------------------------------------------------------
// stt_scan
// Scanner state and the per-byte lexing logic; gives up to two results.
// ---------------------------------------------------------------------------
module stt_scan (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  stt_pkg::sym_t text_byte,
    output stt_pkg::push_t push
);
    import stt_pkg::*;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_UINT  = 3'd2;
    localparam logic [2:0] MODE_POINT = 3'd3;
    localparam logic [2:0] MODE_FRAC  = 3'd4;
    localparam logic [2:0] MODE_MINUS = 3'd5;

    logic [2:0]             mode_reg, mode_next;
    offset_t                pos_reg, pos_next;
    offset_t                start_reg, start_next;
    logic [PREFIX_BITS-1:0] prefix_reg, prefix_next;

    // Outcome of treating the byte as the first byte of a new token.
    logic                   sb_valid;
    res_t                   sb_res;
    logic [2:0]             sb_mode;
    offset_t                sb_start;
    logic [PREFIX_BITS-1:0] sb_prefix;
    logic                   sb_ended;

    offset_t    word_len;
    logic       kw_hit;
    kw_t        kw_idx;
    logic       a_valid, b_valid;
    res_t       a_res, b_res;
    logic       ended;
    logic       finish;
    kind_t      finish_kind;
    logic       take_sb;

    assign word_len = pos_reg - start_reg;

    always_comb
    begin
        sb_valid  = 1'b0;
        sb_res    = make_res(KIND_END, 3'd0, pos_reg, LEN_BITS'(1), CH_NUL, 1'b0,
                             ERR_EXPECT_DELIM);
        sb_mode   = MODE_IDLE;
        sb_start  = start_reg;
        sb_prefix = prefix_reg;
        sb_ended  = 1'b0;
        if (text_byte == CH_NUL)
        begin
            sb_valid = 1'b1;
            sb_ended = 1'b1;
        end
        else if (is_space(text_byte))
        begin
            sb_valid = 1'b0;
        end
        else if (is_digit(text_byte))
        begin
            sb_mode  = MODE_UINT;
            sb_start = pos_reg;
        end
        else if (is_alpha(text_byte))
        begin
            sb_mode   = MODE_IDENT;
            sb_start  = pos_reg;
            sb_prefix = PREFIX_BITS'(text_byte);
        end
        else if (text_byte == CH_MINUS)
        begin
            sb_mode  = MODE_MINUS;
            sb_start = pos_reg;
        end
        else if (is_delim(text_byte))
        begin
            sb_valid = 1'b1;
            sb_res   = make_res(KIND_DELIM, 3'd0, pos_reg, LEN_BITS'(1), text_byte,
                                1'b0, ERR_EXPECT_DELIM);
        end
        else
        begin
            sb_valid = 1'b1;
            sb_res   = make_res(KIND_ERROR, 3'd0, pos_reg, LEN_BITS'(1), text_byte,
                                1'b0, ERR_UNEXPECTED);
        end
    end

    // Keyword compare: length and stored leading characters; lowest index wins.
    always_comb
    begin
        logic same;
        kw_hit = 1'b0;
        kw_idx = 3'd0;
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--)
        begin
            same = (word_len == OFFSET_BITS'(KW_LEN[k])) && (KW_LEN[k] <= KEYWORD_CHARS);
            for (int i = 0; i < KEYWORD_CHARS; i++)
            begin
                if ((i < KW_LEN[k]) && (prefix_reg[8*i +: 8] != KW_TEXT[k][8*i +: 8]))
                begin
                    same = 1'b0;
                end
            end
            if (same)
            begin
                kw_hit = 1'b1;
                kw_idx = 3'(k);
            end
        end
    end

    always_comb
    begin
        a_valid     = 1'b0;
        a_res       = sb_res;
        b_valid     = 1'b0;
        b_res       = sb_res;
        mode_next   = mode_reg;
        start_next  = start_reg;
        prefix_next = prefix_reg;
        ended       = 1'b0;
        finish      = 1'b0;
        finish_kind = KIND_IDENT;
        take_sb     = 1'b0;

        case (mode_reg)
            MODE_IDENT:
            begin
                if (is_alpha(text_byte) || is_digit(text_byte))
                begin
                    for (int i = 0; i < KEYWORD_CHARS; i++)
                    begin
                        if (word_len == OFFSET_BITS'(i))
                        begin
                            prefix_next[8*i +: 8] = prefix_reg[8*i +: 8] | text_byte;
                        end
                    end
                end
                else
                begin
                    finish      = 1'b1;
                    finish_kind = KIND_IDENT;
                end
            end
            MODE_UINT:
            begin
                if (text_byte == CH_POINT)
                begin
                    mode_next = MODE_POINT;
                end
                else if (!is_digit(text_byte))
                begin
                    finish      = 1'b1;
                    finish_kind = KIND_UINT;
                end
            end
            MODE_POINT:
            begin
                if (is_digit(text_byte))
                begin
                    mode_next = MODE_FRAC;
                end
                else
                begin
                    a_valid   = 1'b1;
                    a_res     = make_res(KIND_ERROR, 3'd0, pos_reg, LEN_BITS'(1), text_byte,
                                         1'b0, ERR_EXPECT_DIGIT);
                    mode_next = MODE_IDLE;
                    if (text_byte == CH_NUL)
                    begin
                        b_valid = 1'b1;
                        ended   = 1'b1;
                    end
                end
            end
            MODE_FRAC:
            begin
                if (!is_digit(text_byte))
                begin
                    finish      = 1'b1;
                    finish_kind = KIND_DEC;
                end
            end
            MODE_MINUS:
            begin
                a_valid = 1'b1;
                if (text_byte == CH_GT)
                begin
                    a_res     = make_res(KIND_DELIM, 3'd0, start_reg,
                                         LEN_BITS'(word_len) + LEN_BITS'(1), CH_MINUS,
                                         1'b1, ERR_EXPECT_DELIM);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    a_res   = make_res(KIND_DELIM, 3'd0, start_reg, LEN_BITS'(1), CH_MINUS,
                                       1'b0, ERR_EXPECT_DELIM);
                    take_sb = 1'b1;
                end
            end
            default:
            begin
                take_sb = 1'b1;
            end
        endcase

        // A word or number ended on this byte.
        if (finish)
        begin
            a_valid = 1'b1;
            if (!ends_token(text_byte))
            begin
                a_res     = make_res(KIND_ERROR, 3'd0, pos_reg, LEN_BITS'(1), text_byte,
                                     1'b0, ERR_EXPECT_DELIM);
                mode_next = MODE_IDLE;
            end
            else
            begin
                if ((finish_kind == KIND_IDENT) && kw_hit)
                begin
                    a_res = make_res(KIND_KEYWORD, kw_idx, start_reg, LEN_BITS'(word_len),
                                     CH_NUL, 1'b0, ERR_EXPECT_DELIM);
                end
                else
                begin
                    a_res = make_res(finish_kind, 3'd0, start_reg, LEN_BITS'(word_len),
                                     CH_NUL, 1'b0, ERR_EXPECT_DELIM);
                end
                take_sb = 1'b1;
            end
        end

        if (take_sb)
        begin
            b_valid     = sb_valid;
            b_res       = sb_res;
            mode_next   = sb_mode;
            start_next  = sb_start;
            prefix_next = sb_prefix;
            ended       = sb_ended;
        end

        // The end token returns the scanner to its reset state.
        if (ended)
        begin
            mode_next   = MODE_IDLE;
            start_next  = '0;
            prefix_next = '0;
            pos_next    = '0;
        end
        else if (pos_reg != '1)
        begin
            pos_next = pos_reg + OFFSET_BITS'(1);
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_comb
    begin
        push.count       = accept ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
        push.first       = a_valid ? a_res : b_res;
        push.first.last  = !(a_valid && b_valid);
        push.second      = b_res;
        push.second.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            prefix_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

// ----- rtl/core/stt_result_fifo.sv -----
// ---------------------------------------------------------------------------
// stt_result_fifo
// Result queue that takes up to two results per cycle and gives one.
// ---------------------------------------------------------------------------
module stt_result_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  stt_pkg::push_t push,
    input  logic           pop,
    output stt_pkg::res_t  head,
    output logic           not_empty,
    output logic           has_room
);
    import stt_pkg::*;

    res_t                     store_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;

    assign head      = store_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    // Room for the two results that one byte can cause.
    assign has_room  = (count_reg <= COUNT_BITS'(FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push.count);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
    assign count_next  = count_reg + COUNT_BITS'(push.count) - COUNT_BITS'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            store_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            store_reg[wr_ptr_reg + FIFO_PTR_BITS'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
